FILE: sv/fcpp_pkg.sv
// Shared types, widths and register codes for the frustum cull and projection unit.
// No dependencies.
package fcpp_pkg;

  localparam int CoordW  = 32;
  localparam int HalfW   = 15;
  localparam int AspW    = 16;
  localparam int AspFrac = 8;
  localparam int ScrW    = 16;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;
  localparam int NumW    = HalfW + CoordW;
  localparam int QW      = ScrW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_W = 3'd0,
    REG_HALF_H = 3'd1,
    REG_ASPECT = 3'd2,
    REG_NEAR   = 3'd3,
    REG_FAR    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] view_x;
    logic signed [CoordW-1:0] view_y;
    logic signed [CoordW-1:0] view_z;
  } vtx_t;

  typedef struct packed {
    logic            inside_res;
    logic [ScrW-1:0] screen_col;
    logic [ScrW-1:0] screen_row;
  } res_t;

  typedef struct packed {
    logic              in_view;
    logic              neg_c;
    logic              neg_r;
    logic [NumW-1:0]   num_c;
    logic [NumW-1:0]   num_r;
    logic [CoordW-1:0] den;
  } mid_t;

  typedef struct packed {
    logic [HalfW-1:0]         half_w;
    logic [HalfW-1:0]         half_h;
    logic [AspW-1:0]          aspect;
    logic signed [CoordW-1:0] near_p;
    logic signed [CoordW-1:0] far_p;
  } cfg_t;

endpackage

FILE: sv/fcpp_fifo.sv
// Small register FIFO used for the decoupling and result queues.
// Depends on nothing beyond its parameters.
module fcpp_fifo #(
  parameter int  DEPTH = 4,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end
endmodule

FILE: sv/fcpp_front.sv
// Front end: magnitudes, plane compares, scale products and frustum test.
// Depends on fcpp_pkg.
module fcpp_front
  import fcpp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  vtx_t vtx_i,
  input  cfg_t cfg_i,
  output logic valid_o,
  output mid_t mid_o
);
  logic              a_vld_q, b_vld_q;
  logic [CoordW-1:0] ax_q, ay_q, az_q;
  logic              nx_q, ny_q, nz_q, plane_q;
  mid_t              mid_q;

  logic [NumW-1:0]      pc, pr;
  logic [AspW+CoordW-1:0] py;

  assign pc = NumW'(cfg_i.half_w) * NumW'(ax_q);
  assign pr = NumW'(cfg_i.half_w) * NumW'(ay_q);
  assign py = (AspW+CoordW)'(cfg_i.aspect) * (AspW+CoordW)'(ay_q);

  always_ff @(posedge clk_i) begin
    ax_q    <= vtx_i.view_x[CoordW-1] ? -vtx_i.view_x : vtx_i.view_x;
    ay_q    <= vtx_i.view_y[CoordW-1] ? -vtx_i.view_y : vtx_i.view_y;
    az_q    <= vtx_i.view_z[CoordW-1] ? -vtx_i.view_z : vtx_i.view_z;
    nx_q    <= vtx_i.view_x[CoordW-1];
    ny_q    <= vtx_i.view_y[CoordW-1];
    nz_q    <= vtx_i.view_z[CoordW-1];
    plane_q <= (vtx_i.view_z > cfg_i.near_p) && (vtx_i.view_z < cfg_i.far_p);
    mid_q.in_view <= plane_q && (az_q > ax_q) &&
                     ({(AspW-AspFrac)'(0), az_q, AspFrac'(0)} > py);
    mid_q.neg_c  <= nx_q ^ nz_q;
    mid_q.neg_r  <= ny_q ^ nz_q;
    mid_q.num_c  <= pc;
    mid_q.num_r  <= pr;
    mid_q.den    <= az_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= push_i;
      b_vld_q <= a_vld_q;
    end
  end

  assign valid_o = b_vld_q;
  assign mid_o   = mid_q;
endmodule

FILE: sv/fcpp_back.sv
// Back end: two pipelined restoring dividers, one quotient bit per stage, then clamp.
// Depends on fcpp_pkg.
module fcpp_back
  import fcpp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  mid_t mid_i,
  input  cfg_t cfg_i,
  output logic valid_o,
  output res_t res_o
);
  typedef struct packed {
    logic              in_view;
    logic              neg_c;
    logic              neg_r;
    logic              ovf_c;
    logic              ovf_r;
    logic [CoordW-1:0] den;
    logic [CoordW-1:0] rem_c;
    logic [CoordW-1:0] rem_r;
    logic [QW-1:0]     lo_c;
    logic [QW-1:0]     lo_r;
    logic [QW-1:0]     q_c;
    logic [QW-1:0]     q_r;
  } stg_t;

  function automatic logic [CoordW:0] trial(logic [CoordW-1:0] rem, logic b);
    logic [CoordW:0] t;
    t = {rem, b};
    return t;
  endfunction

  function automatic logic [ScrW-1:0] clamp(logic [HalfW-1:0] c, logic [QW-1:0] q,
                                            logic ovf, logic neg);
    logic signed [QW+1:0] s;
    s = neg ? ((QW+2)'(c) - (QW+2)'(q)) : ((QW+2)'(c) + (QW+2)'(q));
    if (ovf) return neg ? '0 : '1;
    if (s < 0) return '0;
    if (s > (QW+2)'({ScrW{1'b1}})) return '1;
    return s[ScrW-1:0];
  endfunction

  stg_t           st_q [QW+1];
  logic [QW:0]    vld_q;
  res_t           res_q;
  logic           out_vld_q;

  always_ff @(posedge clk_i) begin
    st_q[0].in_view <= mid_i.in_view;
    st_q[0].neg_c  <= mid_i.neg_c;
    st_q[0].neg_r  <= mid_i.neg_r;
    st_q[0].den    <= mid_i.den;
    st_q[0].ovf_c  <= (CoordW'(mid_i.num_c[NumW-1:QW]) >= mid_i.den);
    st_q[0].ovf_r  <= (CoordW'(mid_i.num_r[NumW-1:QW]) >= mid_i.den);
    st_q[0].rem_c  <= CoordW'(mid_i.num_c[NumW-1:QW]);
    st_q[0].rem_r  <= CoordW'(mid_i.num_r[NumW-1:QW]);
    st_q[0].lo_c   <= mid_i.num_c[QW-1:0];
    st_q[0].lo_r   <= mid_i.num_r[QW-1:0];
    st_q[0].q_c    <= '0;
    st_q[0].q_r    <= '0;
    for (int k = 1; k <= QW; k++) begin
      logic [CoordW:0] tc, tr;
      logic            gc, gr;
      tc = trial(st_q[k-1].rem_c, st_q[k-1].lo_c[QW-1]);
      tr = trial(st_q[k-1].rem_r, st_q[k-1].lo_r[QW-1]);
      gc = tc >= {1'b0, st_q[k-1].den};
      gr = tr >= {1'b0, st_q[k-1].den};
      st_q[k].in_view <= st_q[k-1].in_view;
      st_q[k].neg_c   <= st_q[k-1].neg_c;
      st_q[k].neg_r   <= st_q[k-1].neg_r;
      st_q[k].ovf_c   <= st_q[k-1].ovf_c;
      st_q[k].ovf_r   <= st_q[k-1].ovf_r;
      st_q[k].den     <= st_q[k-1].den;
      st_q[k].rem_c <= gc ? CoordW'(tc - {1'b0, st_q[k-1].den}) : tc[CoordW-1:0];
      st_q[k].rem_r <= gr ? CoordW'(tr - {1'b0, st_q[k-1].den}) : tr[CoordW-1:0];
      st_q[k].lo_c  <= {st_q[k-1].lo_c[QW-2:0], 1'b0};
      st_q[k].lo_r  <= {st_q[k-1].lo_r[QW-2:0], 1'b0};
      st_q[k].q_c   <= {st_q[k-1].q_c[QW-2:0], gc};
      st_q[k].q_r   <= {st_q[k-1].q_r[QW-2:0], gr};
    end
    res_q.inside_res <= st_q[QW].in_view;
    res_q.screen_col <= st_q[QW].in_view ?
        clamp(cfg_i.half_w, st_q[QW].q_c, st_q[QW].ovf_c, st_q[QW].neg_c) : '0;
    res_q.screen_row <= st_q[QW].in_view ?
        clamp(cfg_i.half_h, st_q[QW].q_r, st_q[QW].ovf_r, st_q[QW].neg_r) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[QW-1:0], valid_i};
      out_vld_q <= vld_q[QW];
    end
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;
endmodule

FILE: sv/frustum_cull_perspective_project_unit.sv
// Top level of the frustum cull and perspective projection unit.
// Depends on fcpp_pkg, fcpp_front, fcpp_fifo and fcpp_back.
//
// Vertices enter on a queue-style port: a transaction completes when push_i is
// high and full_o is low. Results leave the same way: res_o holds the oldest
// result while empty_o is low and is taken when pop_i is high.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, one
// register per cycle; the user must do so only while no vertex is in flight.
// The block itself does not enforce this. The path runs through the front
// registers, the decoupling queue, the back end (its input register, 17
// divider bit stages and the clamp register) and the result queue.
// Throughput is one vertex per cycle while full_o is low.
// The front stalls only when the decoupling queue has no credit; the back
// draws from it while the result queue has room, so a stalled receiver fills
// OUT_DEPTH results and then backs up into the front and full_o.
// Reset empties all queues and loads the register defaults.
module frustum_cull_perspective_project_unit
  import fcpp_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vtx_t               vtx_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output res_t               res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);
  localparam int FcW = $clog2(MID_DEPTH + 1);
  localparam int BcW = $clog2(OUT_DEPTH + 1);

  cfg_t           cfg_q;
  logic [FcW-1:0] fcnt_q;
  logic [BcW-1:0] bcnt_q;
  logic           push, pop, f_vld, m_empty, m_pop, b_vld;
  mid_t           f_mid, m_mid;
  res_t           b_res;

  assign push   = push_i && !full_o;
  assign pop    = pop_i && !empty_o;
  assign full_o = (fcnt_q == FcW'(MID_DEPTH));
  assign m_pop  = !m_empty && (bcnt_q != BcW'(OUT_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_w <= HalfW'(160);
      cfg_q.half_h <= HalfW'(120);
      cfg_q.aspect <= AspW'(256);
      cfg_q.near_p <= CoordW'(65536);
      cfg_q.far_p  <= CoordW'(6553600);
      fcnt_q       <= '0;
      bcnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HALF_W: cfg_q.half_w <= cfg_data_i[HalfW-1:0];
          REG_HALF_H: cfg_q.half_h <= cfg_data_i[HalfW-1:0];
          REG_ASPECT: cfg_q.aspect <= cfg_data_i[AspW-1:0];
          REG_NEAR:   cfg_q.near_p <= cfg_data_i[CoordW-1:0];
          REG_FAR:    cfg_q.far_p  <= cfg_data_i[CoordW-1:0];
          default: ;
        endcase
      end
      fcnt_q <= fcnt_q + FcW'(push) - FcW'(m_pop);
      bcnt_q <= bcnt_q + BcW'(m_pop) - BcW'(pop);
    end
  end

  fcpp_front u_front (
    .clk_i, .rst_ni, .push_i(push), .vtx_i, .cfg_i(cfg_q),
    .valid_o(f_vld), .mid_o(f_mid)
  );

  fcpp_fifo #(.DEPTH(MID_DEPTH), .T(mid_t)) u_mid_q (
    .clk_i, .rst_ni, .push_i(f_vld), .data_i(f_mid), .pop_i(m_pop),
    .data_o(m_mid), .empty_o(m_empty)
  );

  fcpp_back u_back (
    .clk_i, .rst_ni, .valid_i(m_pop), .mid_i(m_mid), .cfg_i(cfg_q),
    .valid_o(b_vld), .res_o(b_res)
  );

  fcpp_fifo #(.DEPTH(OUT_DEPTH), .T(res_t)) u_out_q (
    .clk_i, .rst_ni, .push_i(b_vld), .data_i(b_res), .pop_i(pop),
    .data_o(res_o), .empty_o(empty_o)
  );

  a_fcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= FcW'(MID_DEPTH)) else $error("decoupling credit overrun");
  a_bcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= BcW'(OUT_DEPTH)) else $error("result credit overrun");
  a_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !res_o.inside_res) |-> (res_o.screen_col == '0 && res_o.screen_row == '0))
    else $error("outside vertex with screen position");
  a_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_pop |-> !m_empty) else $error("pop of empty decoupling queue");
endmodule
